// File: src/midi_loop_phrase_player_defines.svh
`ifndef MIDI_LOOP_PHRASE_PLAYER_DEFINES_SVH
`define MIDI_LOOP_PHRASE_PLAYER_DEFINES_SVH

// same-cycle implication check
`define MLPP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication check
`define MLPP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: src/mlpp_pkg.sv
`default_nettype none
package mlpp_pkg;
   localparam int TICKS_PER_QUARTER_DEF = 24;
   localparam int EVENT_CAPACITY_DEF    = 1024;
   localparam int RECORD_CAPACITY_DEF   = 256;
   localparam int HELD_LIMIT_DEF        = 32;
   localparam int SLOT_LIMIT_DEF        = 16;
   localparam int QUEUE_DEPTH           = 4;

   localparam int CLOCK_W = 15;
   localparam int EVT_W   = 37;
   localparam int NOTES   = 128;
   localparam int COUNT_W = 6;
   localparam int CSR_W   = 5;

   localparam logic [15:0]        LEN_MAX     = 16'd32768;
   localparam logic [3:0]         HI_NOTE_OFF = 4'h8;
   localparam logic [3:0]         HI_NOTE_ON  = 4'h9;
   localparam logic [6:0]         RELEASE_VEL = 7'h7f;
   localparam logic [COUNT_W-1:0] COUNT_MAX   = 6'd63;

   localparam logic [1:0] CSR_BEATS   = 2'd0;
   localparam logic [1:0] CSR_UNIT    = 2'd1;
   localparam logic [1:0] CSR_BARS    = 2'd2;
   localparam logic [1:0] CSR_CHANNEL = 2'd3;

   typedef enum logic [2:0] {
      CMD_TICK   = 3'd0,
      CMD_PLAY   = 3'd1,
      CMD_PAUSE  = 3'd2,
      CMD_STOP   = 3'd3,
      CMD_RECORD = 3'd4,
      CMD_CLEAR  = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_RELEASE  = 2'd0,
      KIND_EVENT    = 2'd1,
      KIND_POSITION = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      TR_STOPPED = 2'd0,
      TR_PLAYING = 2'd1,
      TR_PAUSED  = 2'd2
   } transport_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] status;
      logic [6:0] data_one;
      logic [6:0] data_two;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;
endpackage
`default_nettype wire

// File: src/mlpp_ram.sv
`default_nettype none
module mlpp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// File: src/mlpp_front.sv
`default_nettype none
module mlpp_front import mlpp_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [2:0]    req_mode,
   input  wire logic [7:0]    req_status_byte,
   input  wire logic [6:0]    req_data_one,
   input  wire logic [6:0]    req_data_two,
   output queue_out_type      q_out,
   input  wire logic          q_pop
);
   localparam int QAW = $clog2(QUEUE_DEPTH);
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);

   item_type         entries_ff [QUEUE_DEPTH];
   item_type         entry_in;
   logic [QAW-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [QCW-1:0]   cnt_ff, cnt_in;
   logic             known;
   logic             push;

   // classify the command; unknown modes are dropped here
   always_comb begin
      known    = 1'b1;
      entry_in = '{cmd: CMD_TICK, status: req_status_byte,
                   data_one: req_data_one, data_two: req_data_two};
      unique case (req_mode)
         CMD_TICK:   entry_in.cmd = CMD_TICK;
         CMD_PLAY:   entry_in.cmd = CMD_PLAY;
         CMD_PAUSE:  entry_in.cmd = CMD_PAUSE;
         CMD_STOP:   entry_in.cmd = CMD_STOP;
         CMD_RECORD: entry_in.cmd = CMD_RECORD;
         CMD_CLEAR:  entry_in.cmd = CMD_CLEAR;
         default:    known = 1'b0;
      endcase
   end

   assign req_stall = (cnt_ff == QCW'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall && known;

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = (wp_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      end
      if (q_pop) begin
         rp_in = (rp_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : rp_ff + 1'b1;
      end
      if (push && !q_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && q_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wp_ff] <= entry_in;
      end
   end

   assign q_out.valid = (cnt_ff != '0);
   assign q_out.item  = entries_ff[rp_ff];
endmodule
`default_nettype wire

// File: src/mlpp_back.sv
`default_nettype none
module mlpp_back import mlpp_pkg::*; #(
   parameter int TICKS_PER_QUARTER = TICKS_PER_QUARTER_DEF,
   parameter int EVENT_CAPACITY    = EVENT_CAPACITY_DEF,
   parameter int RECORD_CAPACITY   = RECORD_CAPACITY_DEF,
   parameter int HELD_LIMIT        = HELD_LIMIT_DEF,
   parameter int SLOT_LIMIT        = SLOT_LIMIT_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire queue_out_type    q_out,
   output logic                  q_pop,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [1:0]            rsp_kind,
   output logic [7:0]            rsp_out_status,
   output logic [6:0]            rsp_out_data_one,
   output logic [6:0]            rsp_out_data_two,
   output logic [CLOCK_W-1:0]    rsp_position,
   output logic                  rsp_last
);
   localparam int EV_AW  = $clog2(EVENT_CAPACITY);
   localparam int EC_W   = $clog2(EVENT_CAPACITY + 1);
   localparam int RC_AW  = $clog2(RECORD_CAPACITY);
   localparam int RC_W   = $clog2(RECORD_CAPACITY + 1);
   localparam int TOT_W  = $clog2(HELD_LIMIT + 1);
   localparam int SL_W   = $clog2(SLOT_LIMIT + 1);
   localparam int TPQ_W  = $clog2(TICKS_PER_QUARTER + 1);
   localparam int UP_W   = TPQ_W + 5;
   localparam int CPB_W  = UP_W - 2;
   localparam int PROD_W = CPB_W + 5;
   localparam int FULL_W = PROD_W + 5;

   typedef enum logic [17:0] {
      S_IDLE      = 18'h00001,
      S_LEN1      = 18'h00002,
      S_LEN2      = 18'h00004,
      S_LEN3      = 18'h00008,
      S_SW_RD     = 18'h00010,
      S_SW_WAIT   = 18'h00020,
      S_SW_EMIT   = 18'h00040,
      S_SC_RD     = 18'h00080,
      S_SC_WAIT   = 18'h00100,
      S_SC_EMIT   = 18'h00200,
      S_HD_UPD    = 18'h00400,
      S_ADV       = 18'h00800,
      S_POS       = 18'h01000,
      S_MG_START  = 18'h02000,
      S_MG_RWAIT  = 18'h04000,
      S_MG_CMP_RD = 18'h08000,
      S_MG_CMP    = 18'h10000,
      S_MG_PUT    = 18'h20000
   } state_type;

   state_type            state_ff, state_in;
   logic [4:0]           beats_ff, beats_in, unit_ff, unit_in, bars_ff, bars_in;
   logic [3:0]           chan_ff, chan_in;
   transport_type        transport_ff, transport_in;
   logic [CLOCK_W-1:0]   clock_ff, clock_in, pos_ff, pos_in;
   logic [EC_W-1:0]      ec_ff, ec_in, pp_ff, pp_in, mp_ff, mp_in;
   logic [RC_W-1:0]      rc_ff, rc_in, r_ff, r_in;
   logic [NOTES-1:0]     held_vld_ff, held_vld_in;
   logic [TOT_W-1:0]     total_ff, total_in;
   logic [CPB_W-1:0]     cpb_ff, cpb_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [15:0]          len_ff, len_in;
   logic [6:0]           note_ff, note_in;
   logic [COUNT_W-1:0]   cnt_ff, cnt_in;
   logic [SL_W-1:0]      slots_ff, slots_in;
   logic [7:0]           st_ff, st_in;
   logic [6:0]           d1_ff, d1_in, d2_ff, d2_in;
   logic                 merge_ff, merge_in;
   logic [EVT_W-1:0]     rec_ff, rec_in;

   logic                 rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [1:0]           rsp_kind_ff, rsp_kind_in;
   logic [7:0]           rsp_st_ff, rsp_st_in;
   logic [6:0]           rsp_d1_ff, rsp_d1_in, rsp_d2_ff, rsp_d2_in;
   logic [CLOCK_W-1:0]   rsp_pos_ff, rsp_pos_in;

   logic                 ev_we;
   logic [EV_AW-1:0]     ev_waddr, ev_raddr;
   logic [EVT_W-1:0]     ev_wdata, ev_rdata;
   logic                 rec_we;
   logic [RC_AW-1:0]     rec_waddr, rec_raddr;
   logic [EVT_W-1:0]     rec_wdata, rec_rdata;
   logic                 held_we;
   logic [6:0]           held_addr;
   logic [COUNT_W-1:0]   held_wdata, held_rdata, held_cur;

   logic                 out_free;
   logic [UP_W-1:0]      unit_prod;
   logic [FULL_W-1:0]    full_len;
   logic [CLOCK_W-1:0]   ev_when;
   logic [3:0]           hi_nib;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign unit_prod = UP_W'(unit_ff) * UP_W'(TICKS_PER_QUARTER);
   assign full_len  = FULL_W'(prod_ff) * FULL_W'(bars_ff);
   assign ev_when   = ev_rdata[EVT_W-1:22];
   assign hi_nib    = st_ff[7:4];
   assign held_addr = (state_ff == S_SW_RD || state_ff == S_SW_WAIT) ? note_ff : d1_ff;
   // the read address is held steady while the registered read data arrives, so the valid bit lines up with the data
   assign held_cur  = held_vld_ff[held_addr] ? held_rdata : '0;
   assign q_pop     = (state_ff == S_IDLE) && q_out.valid;

   always_comb begin
      state_in     = state_ff;
      beats_in     = beats_ff;
      unit_in      = unit_ff;
      bars_in      = bars_ff;
      chan_in      = chan_ff;
      transport_in = transport_ff;
      clock_in     = clock_ff;
      pos_in       = pos_ff;
      ec_in        = ec_ff;
      pp_in        = pp_ff;
      mp_in        = mp_ff;
      rc_in        = rc_ff;
      r_in         = r_ff;
      held_vld_in  = held_vld_ff;
      total_in     = total_ff;
      cpb_in       = cpb_ff;
      prod_in      = prod_ff;
      len_in       = len_ff;
      note_in      = note_ff;
      cnt_in       = cnt_ff;
      slots_in     = slots_ff;
      st_in        = st_ff;
      d1_in        = d1_ff;
      d2_in        = d2_ff;
      merge_in     = merge_ff;
      rec_in       = rec_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_d1_in    = rsp_d1_ff;
      rsp_d2_in    = rsp_d2_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_last_in  = rsp_last_ff;
      ev_we        = 1'b0;
      ev_waddr     = mp_ff[EV_AW-1:0];
      ev_wdata     = rec_ff;
      ev_raddr     = pp_ff[EV_AW-1:0];
      rec_we       = 1'b0;
      rec_waddr    = rc_ff[RC_AW-1:0];
      rec_wdata    = {clock_ff, q_out.item.status, q_out.item.data_one,
                      q_out.item.data_two};
      rec_raddr    = r_ff[RC_AW-1:0];
      held_we      = 1'b0;
      held_wdata   = held_cur;

      if (csr_we) begin
         unique case (csr_index)
            CSR_BEATS:   beats_in = csr_wdata;
            CSR_UNIT:    unit_in  = csr_wdata;
            CSR_BARS:    bars_in  = csr_wdata;
            CSR_CHANNEL: chan_in  = csr_wdata[3:0];
            default:     ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (q_out.valid) begin
               unique case (q_out.item.cmd)
                  CMD_TICK: begin
                     pos_in   = clock_ff;
                     slots_in = '0;
                     merge_in = 1'b0;
                     state_in = (transport_ff == TR_PLAYING) ? S_LEN1 : S_POS;
                  end
                  CMD_PLAY:  transport_in = TR_PLAYING;
                  CMD_PAUSE: transport_in = TR_PAUSED;
                  CMD_STOP: begin
                     transport_in = TR_STOPPED;
                     clock_in     = '0;
                     pp_in        = '0;
                     r_in         = '0;
                     state_in     = S_MG_START;
                  end
                  CMD_RECORD: begin
                     if (transport_ff == TR_PLAYING && rc_ff < RC_W'(RECORD_CAPACITY)) begin
                        rec_we = 1'b1;
                        rc_in  = rc_ff + 1'b1;
                     end
                  end
                  CMD_CLEAR: begin
                     if (transport_ff == TR_STOPPED) begin
                        ec_in = '0;
                        pp_in = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_LEN1: begin
            cpb_in   = unit_prod[UP_W-1:2];
            state_in = S_LEN2;
         end
         S_LEN2: begin
            prod_in  = PROD_W'(beats_ff) * PROD_W'(cpb_ff);
            state_in = S_LEN3;
         end
         S_LEN3: begin
            if (full_len == '0) begin
               len_in = 16'd1;
            end else if (full_len > FULL_W'(LEN_MAX)) begin
               len_in = LEN_MAX;
            end else begin
               len_in = 16'(full_len);
            end
            note_in  = '0;
            state_in = (clock_ff == '0) ? S_SW_RD : S_SC_RD;
         end
         S_SW_RD: begin
            if (held_vld_ff[note_ff]) begin
               state_in = S_SW_WAIT;
            end else if (note_ff == 7'(NOTES - 1)) begin
               held_vld_in = '0;
               total_in    = '0;
               state_in    = S_SC_RD;
            end else begin
               note_in = note_ff + 1'b1;
            end
         end
         S_SW_WAIT: begin
            cnt_in   = held_cur;
            state_in = S_SW_EMIT;
         end
         S_SW_EMIT: begin
            if (cnt_ff == '0) begin
               if (note_ff == 7'(NOTES - 1)) begin
                  held_vld_in = '0;
                  total_in    = '0;
                  state_in    = S_SC_RD;
               end else begin
                  note_in  = note_ff + 1'b1;
                  state_in = S_SW_RD;
               end
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_RELEASE;
               rsp_st_in    = {HI_NOTE_OFF, chan_ff};
               rsp_d1_in    = note_ff;
               rsp_d2_in    = RELEASE_VEL;
               rsp_pos_in   = '0;
               rsp_last_in  = 1'b0;
               cnt_in       = cnt_ff - 1'b1;
            end
         end
         S_SC_RD: begin
            state_in = (pp_ff < ec_ff) ? S_SC_WAIT : S_ADV;
         end
         S_SC_WAIT: begin
            if (ev_when <= clock_ff) begin
               if (ev_when == clock_ff && slots_ff < SL_W'(SLOT_LIMIT)) begin
                  st_in    = ev_rdata[21:14];
                  d1_in    = ev_rdata[13:7];
                  d2_in    = ev_rdata[6:0];
                  state_in = S_SC_EMIT;
               end else begin
                  // stale or over the slot limit: consumed silently
                  pp_in    = pp_ff + 1'b1;
                  state_in = S_SC_RD;
               end
            end else begin
               state_in = S_ADV;
            end
         end
         S_SC_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_EVENT;
               rsp_st_in    = st_ff;
               rsp_d1_in    = d1_ff;
               rsp_d2_in    = d2_ff;
               rsp_pos_in   = '0;
               rsp_last_in  = 1'b0;
               slots_in     = slots_ff + 1'b1;
               pp_in        = pp_ff + 1'b1;
               state_in     = (hi_nib == HI_NOTE_OFF || hi_nib == HI_NOTE_ON) ?
                              S_HD_UPD : S_SC_RD;
            end
         end
         S_HD_UPD: begin
            if (hi_nib == HI_NOTE_ON && d2_ff != '0) begin
               if (total_ff < TOT_W'(HELD_LIMIT) && held_cur < COUNT_MAX) begin
                  held_we              = 1'b1;
                  held_wdata           = held_cur + 1'b1;
                  held_vld_in[d1_ff]   = 1'b1;
                  total_in             = total_ff + 1'b1;
               end
            end else if (held_cur != '0) begin
               held_we            = 1'b1;
               held_wdata         = held_cur - 1'b1;
               held_vld_in[d1_ff] = 1'b1;
               if (total_ff != '0) begin
                  total_in = total_ff - 1'b1;
               end
            end
            state_in = S_SC_RD;
         end
         S_ADV: begin
            if ({1'b0, clock_ff} + 16'd1 < len_ff) begin
               clock_in = clock_ff + 1'b1;
            end else begin
               clock_in = '0;
               pp_in    = '0;
               r_in     = '0;
               merge_in = 1'b1;
            end
            state_in = S_POS;
         end
         S_POS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_POSITION;
               rsp_st_in    = '0;
               rsp_d1_in    = '0;
               rsp_d2_in    = '0;
               rsp_pos_in   = pos_ff;
               rsp_last_in  = 1'b1;
               state_in     = merge_ff ? S_MG_START : S_IDLE;
            end
         end
         S_MG_START: begin
            if (r_ff < rc_ff && ec_ff < EC_W'(EVENT_CAPACITY)) begin
               state_in = S_MG_RWAIT;
            end else begin
               rc_in    = '0;
               r_in     = '0;
               state_in = S_IDLE;
            end
         end
         S_MG_RWAIT: begin
            rec_in   = rec_rdata;
            mp_in    = ec_ff;
            state_in = S_MG_CMP_RD;
         end
         S_MG_CMP_RD: begin
            ev_raddr = EV_AW'(mp_ff - 1'b1);
            state_in = (mp_ff == '0) ? S_MG_PUT : S_MG_CMP;
         end
         S_MG_CMP: begin
            // shift later events up one place until the insert point
            if (ev_when > rec_ff[EVT_W-1:22]) begin
               ev_we    = 1'b1;
               ev_wdata = ev_rdata;
               mp_in    = mp_ff - 1'b1;
               state_in = S_MG_CMP_RD;
            end else begin
               state_in = S_MG_PUT;
            end
         end
         S_MG_PUT: begin
            ev_we    = 1'b1;
            ev_wdata = rec_ff;
            ec_in    = ec_ff + 1'b1;
            r_in     = r_ff + 1'b1;
            state_in = S_MG_START;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         beats_ff     <= 5'd4;
         unit_ff      <= 5'd4;
         bars_ff      <= 5'd1;
         chan_ff      <= '0;
         transport_ff <= TR_STOPPED;
         clock_ff     <= '0;
         ec_ff        <= '0;
         pp_ff        <= '0;
         rc_ff        <= '0;
         r_ff         <= '0;
         held_vld_ff  <= '0;
         total_ff     <= '0;
         merge_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         beats_ff     <= beats_in;
         unit_ff      <= unit_in;
         bars_ff      <= bars_in;
         chan_ff      <= chan_in;
         transport_ff <= transport_in;
         clock_ff     <= clock_in;
         ec_ff        <= ec_in;
         pp_ff        <= pp_in;
         rc_ff        <= rc_in;
         r_ff         <= r_in;
         held_vld_ff  <= held_vld_in;
         total_ff     <= total_in;
         merge_ff     <= merge_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      mp_ff       <= mp_in;
      cpb_ff      <= cpb_in;
      prod_ff     <= prod_in;
      len_ff      <= len_in;
      note_ff     <= note_in;
      cnt_ff      <= cnt_in;
      slots_ff    <= slots_in;
      st_ff       <= st_in;
      d1_ff       <= d1_in;
      d2_ff       <= d2_in;
      rec_ff      <= rec_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_d1_ff   <= rsp_d1_in;
      rsp_d2_ff   <= rsp_d2_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_last_ff <= rsp_last_in;
   end

   mlpp_ram #(.WIDTH(EVT_W), .DEPTH(EVENT_CAPACITY)) u_event_ram (
      .clock (clock),
      .we    (ev_we),
      .waddr (ev_waddr),
      .wdata (ev_wdata),
      .raddr (ev_raddr),
      .rdata (ev_rdata)
   );

   mlpp_ram #(.WIDTH(EVT_W), .DEPTH(RECORD_CAPACITY)) u_record_ram (
      .clock (clock),
      .we    (rec_we),
      .waddr (rec_waddr),
      .wdata (rec_wdata),
      .raddr (rec_raddr),
      .rdata (rec_rdata)
   );

   mlpp_ram #(.WIDTH(COUNT_W), .DEPTH(NOTES)) u_held_ram (
      .clock (clock),
      .we    (held_we),
      .waddr (held_addr),
      .wdata (held_wdata),
      .raddr (held_addr),
      .rdata (held_rdata)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_out_status   = rsp_st_ff;
   assign rsp_out_data_one = rsp_d1_ff;
   assign rsp_out_data_two = rsp_d2_ff;
   assign rsp_position     = rsp_pos_ff;
   assign rsp_last         = rsp_last_ff;
endmodule
`default_nettype wire

// File: src/midi_loop_phrase_player.sv
// non-tick commands act in the idle state, record and clear included; stop then merges
// a tick while not playing only emits its position; a playing tick works out the loop
// length, emits due events, drops stale or over-limit ones, then emits its position
// loop start adds a sweep of the 128-entry held-note memory that releases held notes
// a wrap or stop merges each recorded event, shifting later stored events up one place
// command queue of 4 items lets commands arrive while the sequencer is busy
// synchronous reset: transport stopped, clock 0, stores empty, default time signature
`default_nettype none
`include "midi_loop_phrase_player_defines.svh"
module midi_loop_phrase_player import mlpp_pkg::*; #(
   parameter int TICKS_PER_QUARTER = TICKS_PER_QUARTER_DEF,
   parameter int EVENT_CAPACITY    = EVENT_CAPACITY_DEF,
   parameter int RECORD_CAPACITY   = RECORD_CAPACITY_DEF,
   parameter int HELD_LIMIT        = HELD_LIMIT_DEF,
   parameter int SLOT_LIMIT        = SLOT_LIMIT_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [2:0]       req_mode,
   input  wire logic [7:0]       req_status_byte,
   input  wire logic [6:0]       req_data_one,
   input  wire logic [6:0]       req_data_two,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [1:0]            rsp_kind,
   output logic [7:0]            rsp_out_status,
   output logic [6:0]            rsp_out_data_one,
   output logic [6:0]            rsp_out_data_two,
   output logic [CLOCK_W-1:0]    rsp_position,
   output logic                  rsp_last,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata
);
   queue_out_type q_out;
   logic          q_pop;

   mlpp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_status_byte (req_status_byte),
      .req_data_one    (req_data_one),
      .req_data_two    (req_data_two),
      .q_out           (q_out),
      .q_pop           (q_pop)
   );

   mlpp_back #(
      .TICKS_PER_QUARTER (TICKS_PER_QUARTER),
      .EVENT_CAPACITY    (EVENT_CAPACITY),
      .RECORD_CAPACITY   (RECORD_CAPACITY),
      .HELD_LIMIT        (HELD_LIMIT),
      .SLOT_LIMIT        (SLOT_LIMIT)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_out            (q_out),
      .q_pop            (q_pop),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_out_status   (rsp_out_status),
      .rsp_out_data_one (rsp_out_data_one),
      .rsp_out_data_two (rsp_out_data_two),
      .rsp_position     (rsp_position),
      .rsp_last         (rsp_last)
   );

   `MLPP_ASSERT_IMP(a_last_is_pos, clock, reset, rsp_valid && rsp_last,
                    rsp_kind == KIND_POSITION)
   `MLPP_ASSERT_IMP(a_pos_clean, clock, reset, rsp_valid && rsp_kind == KIND_POSITION,
                    rsp_out_status == 8'd0 && rsp_out_data_one == 7'd0 && rsp_last)
   `MLPP_ASSERT_IMP(a_pop_nonempty, clock, reset, q_pop, q_out.valid)
   `MLPP_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid)
endmodule
`default_nettype wire

// File: bench/midi_loop_phrase_player_tb.sv
`default_nettype none
module midi_loop_phrase_player_tb;
   import mlpp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] MODE_SPARE_LO = 3'd6;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;
   localparam int SETTLE_CYCLES = 4000;

   typedef struct {
      logic [CLOCK_W-1:0] stamp;
      logic [7:0]         st;
      logic [6:0]         d1;
      logic [6:0]         d2;
   } loop_event_type;

   typedef struct {
      kind_type           kind;
      logic [7:0]         st;
      logic [6:0]         d1;
      logic [6:0]         d2;
      logic [CLOCK_W-1:0] pos;
      logic               last;
   } midi_msg_type;

   typedef struct {
      logic [2:0]         mode;
      logic [7:0]         st;
      logic [6:0]         d1;
      logic [6:0]         d2;
      bit                 typed;
      logic [CLOCK_W-1:0] tpos;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_mode = '0;
   logic [7:0] req_status_byte = '0;
   logic [6:0] req_data_one = '0;
   logic [6:0] req_data_two = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_out_status;
   logic [6:0] rsp_out_data_one;
   logic [6:0] rsp_out_data_two;
   logic [CLOCK_W-1:0] rsp_position;
   logic rsp_last;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   midi_loop_phrase_player u_top (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("timeout at %0t", $time);
      $display("status: fail");
      $finish;
   end

   // predictor state
   int unsigned beats, unit, bars;
   logic [3:0] rel_channel;
   int unsigned play_clock;
   transport_type deck;
   loop_event_type loop_events[EVENT_CAPACITY_DEF];
   int unsigned loop_event_count, play_ptr;
   loop_event_type overdub[RECORD_CAPACITY_DEF];
   int unsigned overdub_count;
   int unsigned note_held[NOTES];
   int unsigned held_sum;

   midi_msg_type expected_msgs[$];
   int errors = 0;
   int items_sent = 0;
   int msgs_seen = 0;
   int releases_seen = 0;
   int events_seen = 0;
   bit quiet = 0;

   function automatic void predictor_reset();
      beats = 4; unit = 4; bars = 1; rel_channel = '0;
      play_clock = 0; deck = TR_STOPPED;
      loop_event_count = 0; play_ptr = 0; overdub_count = 0;
      foreach (note_held[n]) note_held[n] = 0;
      held_sum = 0;
   endfunction

   function automatic int unsigned loop_length();
      int unsigned len;
      len = beats * ((unit * TICKS_PER_QUARTER_DEF) / 4) * bars;
      if (len == 0) len = 1;
      if (len > LEN_MAX) len = LEN_MAX;
      return len;
   endfunction

   function automatic void add_msg(kind_type k, logic [7:0] st, logic [6:0] d1,
                                   logic [6:0] d2, logic [CLOCK_W-1:0] pos, logic last);
      midi_msg_type m;
      m.kind = k; m.st = st; m.d1 = d1; m.d2 = d2; m.pos = pos; m.last = last;
      expected_msgs.push_back(m);
   endfunction

   function automatic void count_held(loop_event_type e);
      if (e.st[7:4] == HI_NOTE_ON && e.d2 != 0) begin
         if (held_sum < HELD_LIMIT_DEF && note_held[e.d1] < COUNT_MAX) begin
            note_held[e.d1]++;
            held_sum++;
         end
      end else if (e.st[7:4] == HI_NOTE_OFF || e.st[7:4] == HI_NOTE_ON) begin
         if (note_held[e.d1] > 0) begin
            note_held[e.d1]--;
            if (held_sum > 0) held_sum--;
         end
      end
   endfunction

   // recorded events go after stored events of equal time
   function automatic void rewind_and_merge();
      int unsigned p;
      play_clock = 0;
      play_ptr = 0;
      for (int r = 0; r < overdub_count; r++) begin
         if (loop_event_count >= EVENT_CAPACITY_DEF) break;
         p = loop_event_count;
         while (p > 0 && loop_events[p-1].stamp > overdub[r].stamp) p--;
         for (int j = loop_event_count; j > p; j--) loop_events[j] = loop_events[j-1];
         loop_events[p] = overdub[r];
         loop_event_count++;
      end
      overdub_count = 0;
   endfunction

   function automatic void play_command(logic [2:0] mode, logic [7:0] st,
                                        logic [6:0] d1, logic [6:0] d2);
      int unsigned pos, slots;
      loop_event_type e;
      case (mode)
         CMD_TICK: begin
            pos = play_clock;
            if (deck == TR_PLAYING) begin
               slots = 0;
               if (play_clock == 0) begin
                  for (int n = 0; n < NOTES; n++) begin
                     while (note_held[n] > 0) begin
                        add_msg(KIND_RELEASE, {HI_NOTE_OFF, rel_channel}, n[6:0],
                                RELEASE_VEL, '0, 1'b0);
                        note_held[n]--;
                     end
                  end
                  held_sum = 0;
               end
               while (play_ptr < loop_event_count
                      && loop_events[play_ptr].stamp <= play_clock) begin
                  e = loop_events[play_ptr];
                  if (e.stamp == play_clock && slots < SLOT_LIMIT_DEF) begin
                     add_msg(KIND_EVENT, e.st, e.d1, e.d2, '0, 1'b0);
                     count_held(e);
                     slots++;
                  end
                  play_ptr++;
               end
               if (play_clock + 1 < loop_length()) play_clock++;
               else rewind_and_merge();
            end
            add_msg(KIND_POSITION, '0, '0, '0, pos[CLOCK_W-1:0], 1'b1);
         end
         CMD_PLAY: deck = TR_PLAYING;
         CMD_PAUSE: deck = TR_PAUSED;
         CMD_STOP: begin
            deck = TR_STOPPED;
            rewind_and_merge();
         end
         CMD_RECORD: begin
            if (deck == TR_PLAYING && overdub_count < RECORD_CAPACITY_DEF) begin
               overdub[overdub_count] = '{play_clock[CLOCK_W-1:0], st, d1, d2};
               overdub_count++;
            end
         end
         CMD_CLEAR: begin
            if (deck == TR_STOPPED) begin
               loop_event_count = 0;
               play_ptr = 0;
            end
         end
         default: ;
      endcase
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_item(logic [2:0] mode, logic [7:0] st, logic [6:0] d1,
                            logic [6:0] d2);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_status_byte <= st;
      req_data_one <= d1;
      req_data_two <= d2;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      play_command(mode, st, d1, d2);
      items_sent++;
      @(negedge clock);
   endtask

   // drain all results, then give a wrap merge time to finish
   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (expected_msgs.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_setup(int unsigned b, int unsigned u, int unsigned l,
                              int unsigned ch);
      logic [CSR_W-1:0] vals[4];
      logic [1:0] idx[4];
      vals = '{b[CSR_W-1:0], u[CSR_W-1:0], l[CSR_W-1:0], ch[CSR_W-1:0]};
      idx = '{CSR_BEATS, CSR_UNIT, CSR_BARS, CSR_CHANNEL};
      for (int i = 0; i < 4; i++) begin
         csr_we <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         @(negedge clock);
      end
      csr_we <= 1'b0;
      beats = b & 5'h1f; unit = u & 5'h1f; bars = l & 5'h1f; rel_channel = ch[3:0];
      @(negedge clock);
   endtask

   task automatic random_record(bit same_note_on);
      logic [7:0] st;
      int r;
      r = $urandom_range(0, 9);
      if (same_note_on || r < 5) st = {HI_NOTE_ON, 4'($urandom_range(0, 15))};
      else if (r < 7) st = {HI_NOTE_OFF, 4'($urandom_range(0, 15))};
      else st = 8'($urandom_range(0, 255));
      send_item(CMD_RECORD, st,
                7'($urandom_range(0, 3) == 0 ? $urandom_range(0, 127) : $urandom_range(0, 9)),
                7'($urandom_range(0, 4) == 0 ? 0 : $urandom_range(0, 127)));
   endtask

   task automatic random_phase(int unsigned n);
      int unsigned done;
      int r;
      done = 0;
      send_item(CMD_STOP, '0, '0, '0);
      send_item(CMD_CLEAR, '0, '0, '0);
      send_item(CMD_PLAY, '0, '0, '0);
      while (done < n) begin
         r = $urandom_range(0, 99);
         if (r < 45) send_item(CMD_TICK, '0, '0, '0);
         else if (r < 72) random_record(1'b0);
         else if (r < 75) begin
            // crowd one clock past the slot limit
            for (int k = 0; k < 18; k++) random_record(1'b1);
            done += 17;
         end
         else if (r < 80) send_item(CMD_PLAY, '0, '0, '0);
         else if (r < 84) send_item(CMD_PAUSE, '0, '0, '0);
         else if (r < 88) send_item(CMD_STOP, '0, '0, '0);
         else if (r < 92) send_item(CMD_CLEAR, '0, '0, '0);
         else if (r < 96) send_item(r[0] ? MODE_SPARE_LO : MODE_SPARE_HI,
                                    8'($urandom), 7'($urandom), 7'($urandom));
         else send_item(3'($urandom_range(0, 7)), 8'($urandom), 7'($urandom), 7'($urandom));
         done++;
      end
   endtask

   // response side stalls in bursts
   initial begin
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      midi_msg_type m;
      if (!reset && rsp_valid && !rsp_stall) begin
         msgs_seen++;
         if (expected_msgs.size() == 0) begin
            $display("%0t: unexpected item kind %0d status %h pos %0d", $time, rsp_kind,
                     rsp_out_status, rsp_position);
            errors++;
         end else begin
            m = expected_msgs.pop_front();
            if (m.kind == KIND_RELEASE) releases_seen++;
            if (m.kind == KIND_EVENT) events_seen++;
            if (rsp_kind !== m.kind || rsp_out_status !== m.st || rsp_out_data_one !== m.d1
                || rsp_out_data_two !== m.d2 || rsp_position !== m.pos
                || rsp_last !== m.last) begin
               $display("%0t: mismatch expected kind %0d st %h d1 %0d d2 %0d pos %0d last %0d",
                        $time, m.kind, m.st, m.d1, m.d2, m.pos, m.last);
               $display("%0t:            actual kind %0d st %h d1 %0d d2 %0d pos %0d last %0d",
                        $time, rsp_kind, rsp_out_status, rsp_out_data_one,
                        rsp_out_data_two, rsp_position, rsp_last);
               errors++;
            end
         end
      end
   end

   initial begin
      script_row_type script[$];
      script_row_type row;
      predictor_reset();
      script = '{
         '{CMD_TICK,   8'h00, 7'd0,   7'd0,   1'b1, 15'd0},
         '{CMD_RECORD, 8'h90, 7'd60,  7'd100, 1'b0, 15'd0},
         '{CMD_PLAY,   8'h00, 7'd0,   7'd0,   1'b0, 15'd0},
         '{CMD_RECORD, 8'h90, 7'd127, 7'd127, 1'b0, 15'd0},
         '{CMD_RECORD, 8'h9f, 7'd0,   7'd0,   1'b0, 15'd0},
         '{CMD_RECORD, 8'h80, 7'd127, 7'd0,   1'b0, 15'd0},
         '{CMD_RECORD, 8'hff, 7'd127, 7'd127, 1'b0, 15'd0},
         '{CMD_RECORD, 8'h00, 7'd0,   7'd0,   1'b0, 15'd0},
         '{CMD_RECORD, 8'h93, 7'd5,   7'd1,   1'b0, 15'd0},
         '{CMD_STOP,   8'h00, 7'd0,   7'd0,   1'b0, 15'd0},
         '{CMD_PLAY,   8'h00, 7'd0,   7'd0,   1'b0, 15'd0},
         '{CMD_TICK,   8'h00, 7'd0,   7'd0,   1'b0, 15'd0},
         '{CMD_TICK,   8'h00, 7'd0,   7'd0,   1'b0, 15'd0},
         '{CMD_RECORD, 8'hb0, 7'd7,   7'd64,  1'b0, 15'd0},
         '{CMD_PAUSE,  8'h00, 7'd0,   7'd0,   1'b0, 15'd0},
         '{CMD_TICK,   8'h00, 7'd0,   7'd0,   1'b1, 15'd2},
         '{CMD_CLEAR,  8'h00, 7'd0,   7'd0,   1'b0, 15'd0},
         '{MODE_SPARE_LO, 8'h00, 7'd0, 7'd0,  1'b0, 15'd0},
         '{MODE_SPARE_HI, 8'hff, 7'd127, 7'd127, 1'b0, 15'd0},
         '{CMD_PLAY,   8'h00, 7'd0,   7'd0,   1'b0, 15'd0},
         '{CMD_STOP,   8'h00, 7'd0,   7'd0,   1'b0, 15'd0},
         '{CMD_PLAY,   8'h00, 7'd0,   7'd0,   1'b0, 15'd0},
         '{CMD_TICK,   8'h00, 7'd0,   7'd0,   1'b0, 15'd0},
         '{CMD_STOP,   8'h00, 7'd0,   7'd0,   1'b0, 15'd0},
         '{CMD_CLEAR,  8'h00, 7'd0,   7'd0,   1'b0, 15'd0},
         '{CMD_TICK,   8'h00, 7'd0,   7'd0,   1'b1, 15'd0}
      };
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (script[i]) begin
         row = script[i];
         send_item(row.mode, row.st, row.d1, row.d2);
         if (row.typed) begin
            // these rows give only the position, readable by eye
            void'(expected_msgs.pop_back());
            add_msg(KIND_POSITION, '0, '0, '0, row.tpos, 1'b1);
         end
      end
      settle();

      write_setup(1, 1, 1, 15);
      random_phase(24);
      settle();
      write_setup(2, 1, 1, 5);
      random_phase(22);
      settle();
      write_setup(0, 3, 2, 9);
      random_phase(16);
      settle();
      write_setup(31, 31, 31, 0);
      random_phase(16);
      settle();
      quiet = 1;
      write_setup(1, 2, 1, 3);
      random_phase(22);
      settle();

      $display("sent %0d commands, checked %0d results (%0d releases, %0d loop events)",
               items_sent, msgs_seen, releases_seen, events_seen);
      $display("covered six time signatures incl. zero and saturated loop lengths");
      if (errors == 0 && expected_msgs.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
`default_nettype wire
